>>> rtl/fcpt_pkg.sv
// ---------------------------------------------------------------------------
// fcpt_pkg
// Shared widths, the Q2.15 sine table and the saturation helper for the
// Clarke / Park transform pipeline.
// ---------------------------------------------------------------------------
package fcpt_pkg;

  localparam int DataW    = 16;
  localparam int AngleW   = 16;
  localparam int TabIdxW  = 4;                 // 16-entry table
  localparam int FracW    = AngleW - TabIdxW;  // interpolation fraction bits
  localparam int TrigW    = 17;                // sine/cosine incl. +1.0
  localparam int WideW    = 19;                // rounded sums before clipping
  localparam int QuarterTurn = 4;              // table entries in 90 degrees

  // 1/sqrt(3) in Q0.16
  localparam logic [16:0] InvSqrt3Q16 = 17'd37837;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [DataW-1:0] data_t;

  // Clipped value with its overflow flag
  typedef struct packed {
    logic  clipped;
    data_t value;
  } sat_t;

  // Q2.15 sine table, one full turn in 16 steps
  function automatic trig_t sin_tab(input logic [TabIdxW-1:0] idx);
    trig_t v;
    case (idx)
      4'd0:    v = 17'sd0;
      4'd1:    v = 17'sd12540;
      4'd2:    v = 17'sd23170;
      4'd3:    v = 17'sd30274;
      4'd4:    v = 17'sd32768;
      4'd5:    v = 17'sd30274;
      4'd6:    v = 17'sd23170;
      4'd7:    v = 17'sd12540;
      4'd8:    v = 17'sd0;
      4'd9:    v = -17'sd12540;
      4'd10:   v = -17'sd23170;
      4'd11:   v = -17'sd30274;
      4'd12:   v = -17'sd32768;
      4'd13:   v = -17'sd30274;
      4'd14:   v = -17'sd23170;
      4'd15:   v = -17'sd12540;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  // Clip a wide signed value to the Q1.15 range
  function automatic sat_t clip_q15(input logic signed [WideW-1:0] v);
    sat_t r;
    if (v > 19'sd32767) begin
      r.clipped = 1'b1;
      r.value   = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r.clipped = 1'b1;
      r.value   = 16'sh8000;
    end else begin
      r.clipped = 1'b0;
      r.value   = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/fcpt_sincos.sv
// ---------------------------------------------------------------------------
// fcpt_sincos
// Three-stage sine/cosine generator: table lookup, fraction multiply,
// rounding and add. Cosine reads the table a quarter turn ahead.
// ---------------------------------------------------------------------------
module fcpt_sincos
  import fcpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,     // advance all stages
  input  logic [AngleW-1:0] angle_i,
  output trig_t             sin_o,    // registered; valid once angle_i has passed every stage
  output trig_t             cos_o
);

  logic [TabIdxW-1:0] idx0, idx1, cidx0, cidx1;
  trig_t              s0_d, s1_d, c0_d, c1_d;

  trig_t                s0_q, c0_q, s0_2q, c0_2q;
  logic signed [17:0]   ds_q, dc_q;
  logic [FracW-1:0]     frac_q;
  logic signed [30:0]   ps_q, pc_q;
  logic signed [30:0]   ps_rnd, pc_rnd;
  trig_t                sin_q, cos_q;

  // Look up neighbors for sine and cosine
  assign idx0  = angle_i[AngleW-1 -: TabIdxW];
  assign idx1  = idx0 + TabIdxW'(1);
  assign cidx0 = idx0 + TabIdxW'(QuarterTurn);
  assign cidx1 = idx1 + TabIdxW'(QuarterTurn);
  assign s0_d  = sin_tab(idx0);
  assign s1_d  = sin_tab(idx1);
  assign c0_d  = sin_tab(cidx0);
  assign c1_d  = sin_tab(cidx1);

  // Stage 1: base values and slopes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q   <= s0_d;
      c0_q   <= c0_d;
      ds_q   <= 18'(s1_d) - 18'(s0_d);
      dc_q   <= 18'(c1_d) - 18'(c0_d);
      frac_q <= angle_i[FracW-1:0];
    end
  end

  // Stage 2: slope times fraction
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_2q <= s0_q;
      c0_2q <= c0_q;
      ps_q  <= ds_q * $signed({1'b0, frac_q});
      pc_q  <= dc_q * $signed({1'b0, frac_q});
    end
  end

  // Stage 3: round half up and add the base
  assign ps_rnd = (ps_q + 31'sd2048) >>> FracW;
  assign pc_rnd = (pc_q + 31'sd2048) >>> FracW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= s0_2q + $signed(ps_rnd[TrigW-1:0]);
      cos_q <= c0_2q + $signed(pc_rnd[TrigW-1:0]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> rtl/foc_clarke_park_transform.sv
// ---------------------------------------------------------------------------
// foc_clarke_park_transform
// Two-sensor Clarke, Park and inverse Park transform with interpolated
// sine/cosine, Q1.15 data and saturating outputs.
// ---------------------------------------------------------------------------
// An accepted input word passes through the stage registers in order to its output word.
// Throughput: one word per cycle; the five stages advance together and
// hold as a whole while the output word waits for m_axis_tready_i.
// Reset clears the stage valid bits only; data registers are not reset.
// ---------------------------------------------------------------------------
module foc_clarke_park_transform
  import fcpt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // current_a, current_b, elec_angle, volt_d_cmd, volt_q_cmd (lowest first)
  input  logic [79:0]   s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // i_alpha, i_beta, i_direct, i_quad, v_alpha, v_beta, sine, cosine
  output logic [127:0]  m_axis_tdata_o,
  // saturated
  output logic [0:0]    m_axis_tuser_o
);

  localparam int Stages = 5;

  logic              en;
  logic [Stages-1:0] vld_q;

  data_t             cur_a, cur_b, vd_in, vq_in;
  logic [AngleW-1:0] angle;

  // Stage registers
  logic signed [17:0] bsum_q;
  data_t              a1_q, vd1_q, vq1_q;
  logic signed [34:0] bprod_q;
  data_t              a2_q, vd2_q, vq2_q;
  logic signed [34:0] brnd;
  sat_t               beta_sat;
  data_t              alpha3_q, beta3_q, vd3_q, vq3_q;
  logic               bclip3_q;
  trig_t              sin3, cos3;
  logic signed [32:0] p_ac_q, p_bs_q, p_bc_q, p_as_q;
  logic signed [32:0] p_dc_q, p_qs_q, p_ds_q, p_qc_q;
  data_t              alpha4_q, beta4_q;
  trig_t              sin4_q, cos4_q;
  logic               bclip4_q;
  logic signed [33:0] sum_id, sum_iq, sum_va, sum_vb;
  sat_t               id_s, iq_s, va_s, vb_s, so_s, co_s;
  logic [127:0]       out_q;
  logic               sat_q;

  // Unpack the input word
  assign cur_a = s_axis_tdata_i[15:0];
  assign cur_b = s_axis_tdata_i[31:16];
  assign angle = s_axis_tdata_i[47:32];
  assign vd_in = s_axis_tdata_i[63:48];
  assign vq_in = s_axis_tdata_i[79:64];

  // Advance the whole pipe unless the output word is stalled
  assign en              = ~vld_q[Stages-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid_i};
    end
  end

  fcpt_sincos u_sincos (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle),
    .sin_o   (sin3),
    .cos_o   (cos3)
  );

  // Stage 1: Clarke numerator a + 2b
  always_ff @(posedge clk_i) begin
    if (en) begin
      bsum_q <= 18'(cur_a) + (18'(cur_b) <<< 1);
      a1_q   <= cur_a;
      vd1_q  <= vd_in;
      vq1_q  <= vq_in;
    end
  end

  // Stage 2: scale by 1/sqrt(3)
  always_ff @(posedge clk_i) begin
    if (en) begin
      bprod_q <= bsum_q * $signed(InvSqrt3Q16);
      a2_q    <= a1_q;
      vd2_q   <= vd1_q;
      vq2_q   <= vq1_q;
    end
  end

  // Stage 3: round and clip beta
  assign brnd     = (bprod_q + 35'sd32768) >>> 16;
  assign beta_sat = clip_q15(brnd[WideW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha3_q <= a2_q;
      beta3_q  <= beta_sat.value;
      bclip3_q <= beta_sat.clipped;
      vd3_q    <= vd2_q;
      vq3_q    <= vq2_q;
    end
  end

  // Stage 4: all rotation products
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ac_q   <= alpha3_q * cos3;
      p_bs_q   <= beta3_q * sin3;
      p_bc_q   <= beta3_q * cos3;
      p_as_q   <= alpha3_q * sin3;
      p_dc_q   <= vd3_q * cos3;
      p_qs_q   <= vq3_q * sin3;
      p_ds_q   <= vd3_q * sin3;
      p_qc_q   <= vq3_q * cos3;
      alpha4_q <= alpha3_q;
      beta4_q  <= beta3_q;
      sin4_q   <= sin3;
      cos4_q   <= cos3;
      bclip4_q <= bclip3_q;
    end
  end

  // Stage 5: sum, round, clip and pack
  assign sum_id = (p_ac_q + p_bs_q + 34'sd16384) >>> 15;
  assign sum_iq = (p_bc_q - p_as_q + 34'sd16384) >>> 15;
  assign sum_va = (p_dc_q - p_qs_q + 34'sd16384) >>> 15;
  assign sum_vb = (p_ds_q + p_qc_q + 34'sd16384) >>> 15;
  assign id_s   = clip_q15(sum_id[WideW-1:0]);
  assign iq_s   = clip_q15(sum_iq[WideW-1:0]);
  assign va_s   = clip_q15(sum_va[WideW-1:0]);
  assign vb_s   = clip_q15(sum_vb[WideW-1:0]);
  assign so_s   = clip_q15(WideW'(sin4_q));
  assign co_s   = clip_q15(WideW'(cos4_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {co_s.value, so_s.value, vb_s.value, va_s.value,
                iq_s.value, id_s.value, beta4_q, alpha4_q};
      sat_q <= bclip4_q | id_s.clipped | iq_s.clipped | va_s.clipped
             | vb_s.clipped | so_s.clipped | co_s.clipped;
    end
  end

  assign m_axis_tvalid_o = vld_q[Stages-1];
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = sat_q;

  // A flagged word has at least one field on a rail
  logic [7:0] on_rail;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      on_rail[k] = (out_q[16*k +: 16] == 16'h7FFF) || (out_q[16*k +: 16] == 16'h8000);
    end
  end

  ap_sat_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (on_rail != 8'd0))
    else $error("saturated flag set with no clipped field");

  ap_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  ap_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("stage valid raised without an accepted word");

  ap_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

endmodule
